@@ design/sfd_pkg.sv @@
// Shared types and constants of the stereo feedback delay.
package sfd_pkg;

  localparam int unsigned LINE_DEPTH = 16384;
  localparam int unsigned PTR_W      = $clog2(LINE_DEPTH);
  localparam int unsigned SUM_W      = PTR_W + 2;
  localparam int unsigned LEN_W      = 14;
  localparam int unsigned SAMPLE_W   = 16;
  localparam int unsigned GAIN_W     = 16;
  localparam int unsigned SCALE_W    = SAMPLE_W + 1;
  localparam int unsigned PROD_W     = SAMPLE_W + GAIN_W + 1;
  localparam int unsigned WIDE_W     = SAMPLE_W + 2;
  localparam int unsigned PAIR_W     = 2 * SAMPLE_W;
  localparam int unsigned GAIN_FRAC  = 15;
  localparam int unsigned GAIN_ONE   = 32768;
  localparam int unsigned LEN_RESET  = 8192;
  localparam int unsigned ADDR_W     = 4;
  localparam int unsigned APB_W      = 32;
  localparam int unsigned OUT_DEPTH  = 4;
  localparam int unsigned OUT_PTR_W  = $clog2(OUT_DEPTH);
  localparam int unsigned OUT_CNT_W  = OUT_PTR_W + 1;

  typedef logic signed [SAMPLE_W-1:0] sample_t;
  typedef logic signed [SCALE_W-1:0]  scaled_t;
  typedef logic        [PTR_W-1:0]    ptr_t;
  typedef logic        [SUM_W-1:0]    sum_t;

  typedef enum logic [1:0] {
    REG_DELAY_LENGTH  = 2'd0,
    REG_MIX_LEVEL     = 2'd1,
    REG_FEEDBACK_GAIN = 2'd2
  } reg_idx_e;

endpackage

@@ design/sfd_ram.sv @@
// Generic simple dual-port RAM with one write port and a registered read port.
module sfd_ram #(
  parameter int unsigned WIDTH = 32,
  parameter int unsigned DEPTH = 16384,
  localparam int unsigned AW = $clog2(DEPTH)
) (
  input  logic             clk_i,
  input  logic             we_i,
  input  logic [AW-1:0]    waddr_i,
  input  logic [WIDTH-1:0] wdata_i,
  input  logic [AW-1:0]    raddr_i,
  output logic [WIDTH-1:0] rdata_o
);

  logic [WIDTH-1:0] mem [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem[waddr_i] <= wdata_i;
    end
    rdata_q <= mem[raddr_i];
  end

  assign rdata_o = rdata_q;

endmodule

@@ design/stereo_feedback_delay.sv @@
// Stereo feedback delay line: ring buffer memory, tap read, scaling and write-back.
//
// Input samples arrive as stream transactions on s_axis (left in the low half
// of tdata, right in the high half); each produces exactly one output pair on
// m_axis in the same packing. Delay length, mix level and feedback gain are
// programmed over the APB port; the user must do so only while the block is idle
// (the block itself does not enforce this). Both delay lines share one 32-bit wide
// memory with a registered read. The tap is read at the acceptance edge, both
// gains are multiplied in the next cycle and the sums are saturated, written
// back and queued in the cycle after.
// The pipeline accepts one pair per cycle unless the input is held. When the tap
// is an entry still in flight (delay length of two or three) the input is held
// until that write lands, which lowers the rate at those two lengths.
// A four-entry output queue decouples the sides; the input is also held when
// the queue and the pipeline together hold four pairs, so a stalled receiver
// never loses a result.
// Reset sets default settings and clears the write pointer. The memory is not swept;
// entries not yet written since reset read as zero, so the block is ready at once.
module stereo_feedback_delay
  import sfd_pkg::*;
(
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              s_axis_tvalid,
  output logic              s_axis_tready,
  input  logic [PAIR_W-1:0] s_axis_tdata,   // in_left [15:0], in_right [31:16]
  output logic              m_axis_tvalid,
  input  logic              m_axis_tready,
  output logic [PAIR_W-1:0] m_axis_tdata,   // out_left [15:0], out_right [31:16]
  input  logic              psel,
  input  logic              penable,
  input  logic              pwrite,
  input  logic [ADDR_W-1:0] paddr,
  input  logic [APB_W-1:0]  pwdata,
  output logic [APB_W-1:0]  prdata,
  output logic              pready
);

  localparam sum_t DEPTH_S = SUM_W'(LINE_DEPTH);
  localparam sum_t MAXLEN_S = SUM_W'(LINE_DEPTH - 1);
  localparam ptr_t LAST_PTR = PTR_W'(LINE_DEPTH - 1);
  localparam logic [SCALE_W-1:0] GAIN_ONE_S = SCALE_W'(GAIN_ONE);

  function automatic sample_t sat16(input logic signed [WIDE_W-1:0] v);
    logic signed [WIDE_W-1:0] hi;
    logic signed [WIDE_W-1:0] lo;
    hi = WIDE_W'(32767);
    lo = -WIDE_W'(32768);
    if (v > hi) begin
      return sample_t'(hi);
    end else if (v < lo) begin
      return sample_t'(lo);
    end
    return v[SAMPLE_W-1:0];
  endfunction

  // Configuration registers.
  logic [LEN_W-1:0]  len_q;
  logic [GAIN_W-1:0] mix_q;
  logic [GAIN_W-1:0] fb_q;
  logic              cfg_we;

  assign pready = 1'b1;
  assign cfg_we = psel & penable & pwrite & pready;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      len_q <= LEN_W'(LEN_RESET);
      mix_q <= '0;
      fb_q  <= '0;
    end else if (cfg_we) begin
      case (reg_idx_e'(paddr[3:2]))
        REG_DELAY_LENGTH:  len_q <= pwdata[LEN_W-1:0];
        REG_MIX_LEVEL:     mix_q <= pwdata[GAIN_W-1:0];
        REG_FEEDBACK_GAIN: fb_q  <= pwdata[GAIN_W-1:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    case (reg_idx_e'(paddr[3:2]))
      REG_DELAY_LENGTH:  prdata = APB_W'(len_q);
      REG_MIX_LEVEL:     prdata = APB_W'(mix_q);
      REG_FEEDBACK_GAIN: prdata = APB_W'(fb_q);
      default:           prdata = '0;
    endcase
  end

  // Effective length and gains.
  sum_t                len_x;
  sum_t                len_c;
  logic [SCALE_W-1:0]  mix_c;
  logic [SCALE_W-1:0]  fb_c;

  always_comb begin
    len_x = SUM_W'(len_q);
    if (len_x == '0) begin
      len_c = SUM_W'(1);
    end else if (len_x > MAXLEN_S) begin
      len_c = MAXLEN_S;
    end else begin
      len_c = len_x;
    end
    mix_c = (SCALE_W'(mix_q) > GAIN_ONE_S) ? GAIN_ONE_S : SCALE_W'(mix_q);
    fb_c  = (SCALE_W'(fb_q) > GAIN_ONE_S) ? GAIN_ONE_S : SCALE_W'(fb_q);
  end

  // Write pointer and fill tracking.
  ptr_t wr_q;
  logic wrapped_q;

  // Pipeline stage registers.
  logic    vb_q;
  sample_t b_xl_q, b_xr_q;
  ptr_t    b_wr_q;
  logic    b_use_x_q;
  logic    b_live_q;

  logic    vc_q;
  sample_t c_xl_q, c_xr_q;
  ptr_t    c_wr_q;
  scaled_t c_mix_l_q, c_mix_r_q, c_fb_l_q, c_fb_r_q;

  // Output queue.
  logic [PAIR_W-1:0]    fifo_q [OUT_DEPTH];
  logic [OUT_PTR_W-1:0] head_q, tail_q;
  logic [OUT_CNT_W-1:0] cnt_q;
  logic [OUT_CNT_W-1:0] load;
  logic                 pop;

  // Tap address and hazard check.
  sum_t tap_sum;
  ptr_t tap;
  logic hit;
  logic room;
  logic in_fire;

  always_comb begin
    tap_sum = SUM_W'(wr_q) + SUM_W'(1) + DEPTH_S - len_c;
    if (tap_sum >= DEPTH_S) begin
      tap_sum = tap_sum - DEPTH_S;
    end
    tap  = tap_sum[PTR_W-1:0];
    hit  = (vb_q && tap == b_wr_q) || (vc_q && tap == c_wr_q);
    load = cnt_q + OUT_CNT_W'(vb_q) + OUT_CNT_W'(vc_q);
    room = load < OUT_CNT_W'(OUT_DEPTH);
  end

  assign s_axis_tready = room & ~hit;
  assign in_fire       = s_axis_tvalid & s_axis_tready;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_q      <= '0;
      wrapped_q <= 1'b0;
    end else if (in_fire) begin
      if (wr_q == LAST_PTR) begin
        wr_q      <= '0;
        wrapped_q <= 1'b1;
      end else begin
        wr_q <= wr_q + PTR_W'(1);
      end
    end
  end

  // Delay line memory: left in the low half, right in the high half.
  logic [PAIR_W-1:0] rdata;
  logic [PAIR_W-1:0] wdata;

  sfd_ram #(
    .WIDTH(PAIR_W),
    .DEPTH(LINE_DEPTH)
  ) u_line (
    .clk_i  (clk_i),
    .we_i   (vc_q),
    .waddr_i(c_wr_q),
    .wdata_i(wdata),
    .raddr_i(tap),
    .rdata_o(rdata)
  );

  // Stage B: select the tap and scale it by both gains.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vb_q <= 1'b0;
    end else begin
      vb_q <= in_fire;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_fire) begin
      b_xl_q    <= s_axis_tdata[SAMPLE_W-1:0];
      b_xr_q    <= s_axis_tdata[PAIR_W-1:SAMPLE_W];
      b_wr_q    <= wr_q;
      b_use_x_q <= (len_c == SUM_W'(1));
      b_live_q  <= wrapped_q || (tap < wr_q);
    end
  end

  sample_t tl, tr;
  logic signed [PROD_W-1:0] pml, pmr, pfl, pfr;

  always_comb begin
    if (b_use_x_q) begin
      tl = b_xl_q;
      tr = b_xr_q;
    end else if (b_live_q) begin
      tl = rdata[SAMPLE_W-1:0];
      tr = rdata[PAIR_W-1:SAMPLE_W];
    end else begin
      tl = '0;
      tr = '0;
    end
    pml = PROD_W'(tl) * PROD_W'($signed(mix_c));
    pmr = PROD_W'(tr) * PROD_W'($signed(mix_c));
    pfl = PROD_W'(tl) * PROD_W'($signed(fb_c));
    pfr = PROD_W'(tr) * PROD_W'($signed(fb_c));
  end

  // Stage C: add, saturate, write back and queue the result.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vc_q <= 1'b0;
    end else begin
      vc_q <= vb_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (vb_q) begin
      c_xl_q    <= b_xl_q;
      c_xr_q    <= b_xr_q;
      c_wr_q    <= b_wr_q;
      c_mix_l_q <= pml[GAIN_FRAC+SCALE_W-1:GAIN_FRAC];
      c_mix_r_q <= pmr[GAIN_FRAC+SCALE_W-1:GAIN_FRAC];
      c_fb_l_q  <= pfl[GAIN_FRAC+SCALE_W-1:GAIN_FRAC];
      c_fb_r_q  <= pfr[GAIN_FRAC+SCALE_W-1:GAIN_FRAC];
    end
  end

  sample_t yl, yr, wl, wr;

  always_comb begin
    yl = sat16(WIDE_W'(c_xl_q) + WIDE_W'(c_mix_l_q));
    yr = sat16(WIDE_W'(c_xr_q) + WIDE_W'(c_mix_r_q));
    wl = sat16(WIDE_W'(c_xl_q) + WIDE_W'(c_fb_l_q));
    wr = sat16(WIDE_W'(c_xr_q) + WIDE_W'(c_fb_r_q));
  end

  assign wdata = {wr, wl};

  // Output queue.
  assign m_axis_tvalid = (cnt_q != '0);
  assign m_axis_tdata  = fifo_q[head_q];
  assign pop           = m_axis_tvalid & m_axis_tready;

  always_ff @(posedge clk_i) begin
    if (vc_q) begin
      fifo_q[tail_q] <= {yr, yl};
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      head_q <= '0;
      tail_q <= '0;
      cnt_q  <= '0;
    end else begin
      if (vc_q) begin
        tail_q <= tail_q + OUT_PTR_W'(1);
      end
      if (pop) begin
        head_q <= head_q + OUT_PTR_W'(1);
      end
      cnt_q <= cnt_q + OUT_CNT_W'(vc_q) - OUT_CNT_W'(pop);
    end
  end

endmodule

@@ tb/sv/tb.sv @@
// Self-checking testbench for the stereo feedback delay: stream traffic, APB setup, echo predictor.
`timescale 1ns / 100ps

module tb
  import sfd_pkg::*;
();

  localparam int unsigned CYCLE_LIMIT = 400000;
  localparam int unsigned HOLD_CYCLES = 300;
  localparam int unsigned SETTLE      = 8;

  typedef struct packed {
    sample_t right;
    sample_t left;
  } pair_t;

  logic              clk_i = 1'b0;
  logic              rst_ni = 1'b0;
  logic              s_axis_tvalid = 1'b0;
  logic              s_axis_tready;
  logic [PAIR_W-1:0] s_axis_tdata = '0;    // in_left [15:0], in_right [31:16]
  logic              m_axis_tvalid;
  logic              m_axis_tready = 1'b0;
  logic [PAIR_W-1:0] m_axis_tdata;         // out_left [15:0], out_right [31:16]
  logic              psel = 1'b0;
  logic              penable = 1'b0;
  logic              pwrite = 1'b0;
  logic [ADDR_W-1:0] paddr = '0;
  logic [APB_W-1:0]  pwdata = '0;
  logic [APB_W-1:0]  prdata;
  logic              pready;

  stereo_feedback_delay u_dut (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .psel          (psel),
    .penable       (penable),
    .pwrite        (pwrite),
    .paddr         (paddr),
    .pwdata        (pwdata),
    .prdata        (prdata),
    .pready        (pready)
  );

  always begin
    #5 clk_i = 1'b1;
    #5 clk_i = 1'b0;
  end

  sample_t            line_mem [2][LINE_DEPTH];
  ptr_t               wr_ptr;
  logic [LEN_W-1:0]   cfg_len;
  logic [GAIN_W-1:0]  cfg_mix;
  logic [GAIN_W-1:0]  cfg_fb;

  pair_t pending_pairs[$];
  int    pairs_sent;
  int    pairs_checked;
  int    mismatches;
  int    settings_count;
  int    cycle_count;
  bit    tx_idle_en = 1'b1;
  bit    rx_idle_en = 1'b1;
  int    rx_gap;
  int    rx_hold;

  function automatic int scale_tap(sample_t t, int g);
    int p;
    p = int'(t) * g;
    return p >>> GAIN_FRAC;
  endfunction

  function automatic sample_t sat16(int v);
    if (v > 32767) return 16'sh7FFF;
    if (v < -32768) return 16'sh8000;
    return sample_t'(v);
  endfunction

  function automatic int clamp_gain(logic [GAIN_W-1:0] g);
    return (int'(g) > GAIN_ONE) ? GAIN_ONE : int'(g);
  endfunction

  function automatic pair_t echo_pair(pair_t in_pair);
    int      len;
    int      mix;
    int      fb;
    int      tap;
    sample_t x [2];
    sample_t y [2];
    sample_t t;
    pair_t   out_pair;
    len = int'(cfg_len);
    if (len < 1) len = 1;
    if (len > LINE_DEPTH - 1) len = LINE_DEPTH - 1;
    mix = clamp_gain(cfg_mix);
    fb  = clamp_gain(cfg_fb);
    tap = (int'(wr_ptr) + 1 + LINE_DEPTH - len) % LINE_DEPTH;
    x[0] = in_pair.left;
    x[1] = in_pair.right;
    for (int ch = 0; ch < 2; ch++) begin
      line_mem[ch][wr_ptr] = x[ch];
      t = line_mem[ch][tap];
      y[ch] = sat16(int'(x[ch]) + scale_tap(t, mix));
      line_mem[ch][wr_ptr] = sat16(int'(x[ch]) + scale_tap(t, fb));
    end
    wr_ptr = wr_ptr + PTR_W'(1);
    out_pair.left  = y[0];
    out_pair.right = y[1];
    return out_pair;
  endfunction

  // Receiver side: a long hold-off takes priority over the per-transaction gap.
  always @(negedge clk_i) begin
    if (rx_hold > 0) begin
      m_axis_tready <= 1'b0;
      rx_hold = rx_hold - 1;
    end else if (rx_gap > 0) begin
      m_axis_tready <= 1'b0;
      rx_gap = rx_gap - 1;
    end else begin
      m_axis_tready <= 1'b1;
    end
  end

  always @(posedge clk_i) begin
    pair_t got;
    pair_t want;
    if (rst_ni && m_axis_tvalid && m_axis_tready) begin
      got = m_axis_tdata;
      rx_gap = rx_idle_en ? $urandom_range(0, 9) : 0;
      if (pending_pairs.size() == 0) begin
        $display("%0t: unexpected result, expected none, actual %h", $time, got);
        mismatches++;
      end else begin
        want = pending_pairs.pop_front();
        pairs_checked++;
        if (got.left !== want.left) begin
          $display("%0t: out_left mismatch, expected %0d, actual %0d",
                   $time, want.left, got.left);
          mismatches++;
        end
        if (got.right !== want.right) begin
          $display("%0t: out_right mismatch, expected %0d, actual %0d",
                   $time, want.right, got.right);
          mismatches++;
        end
      end
    end
  end

  always @(posedge clk_i) begin
    cycle_count++;
    if (cycle_count > CYCLE_LIMIT) begin
      $display("%0t: timeout with %0d results outstanding", $time, pending_pairs.size());
      $display("CHECK FAILED");
      $finish;
    end
  end

  task automatic send_pair(sample_t l, sample_t r);
    int    gap;
    pair_t in_pair;
    gap = tx_idle_en ? $urandom_range(0, 9) : 0;
    if (gap > 0) begin
      s_axis_tvalid <= 1'b0;
      repeat (gap) @(negedge clk_i);
    end
    in_pair.left  = l;
    in_pair.right = r;
    s_axis_tvalid <= 1'b1;
    s_axis_tdata  <= in_pair;
    do @(posedge clk_i); while (!s_axis_tready);
    pending_pairs.push_back(echo_pair(in_pair));
    pairs_sent++;
    @(negedge clk_i);
  endtask

  task automatic drain();
    s_axis_tvalid <= 1'b0;
    while (pending_pairs.size() != 0) @(posedge clk_i);
    repeat (SETTLE) @(posedge clk_i);
    @(negedge clk_i);
  endtask

  task automatic write_reg(reg_idx_e idx, logic [APB_W-1:0] value);
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= 1'b1;
    paddr   <= ADDR_W'({idx, 2'b00});
    pwdata  <= value;
    @(negedge clk_i);
    penable <= 1'b1;
    do @(posedge clk_i); while (!pready);
    case (idx)
      REG_DELAY_LENGTH:  cfg_len = value[LEN_W-1:0];
      REG_MIX_LEVEL:     cfg_mix = value[GAIN_W-1:0];
      REG_FEEDBACK_GAIN: cfg_fb  = value[GAIN_W-1:0];
      default: ;
    endcase
    @(negedge clk_i);
    psel    <= 1'b0;
    penable <= 1'b0;
    pwrite  <= 1'b0;
  endtask

  task automatic configure(int len, int mix, int fb);
    drain();
    write_reg(REG_DELAY_LENGTH, len);
    write_reg(REG_MIX_LEVEL, mix);
    write_reg(REG_FEEDBACK_GAIN, fb);
    settings_count++;
  endtask

  function automatic sample_t rand_sample();
    case ($urandom_range(0, 9))
      0:       return 16'sh7FFF;
      1:       return 16'sh8000;
      2:       return sample_t'(int'($urandom_range(0, 511)) - 256);
      default: return sample_t'($urandom);
    endcase
  endfunction

  function automatic int rand_gain();
    case ($urandom_range(0, 9))
      0:       return 0;
      1:       return GAIN_ONE;
      2:       return $urandom_range(GAIN_ONE + 1, 65535);
      default: return $urandom_range(0, GAIN_ONE);
    endcase
  endfunction

  function automatic int rand_length();
    case ($urandom_range(0, 9))
      0:       return $urandom_range(0, 3);
      1:       return LINE_DEPTH - 1;
      2:       return $urandom_range(1000, LINE_DEPTH - 1);
      3, 4:    return $urandom_range(41, 999);
      default: return $urandom_range(1, 40);
    endcase
  endfunction

  // With the reset settings the tap has no gain, so every output equals its input.
  task automatic test_reset_bypass();
    send_pair(16'sh7FFF, 16'sh8000);
    send_pair(16'sh8000, 16'sh7FFF);
    send_pair(16'sh0000, -16'sd1);
    send_pair(16'sh5555, 16'shAAAA);
  endtask

  task automatic test_short_taps();
    configure(1, 65535, GAIN_ONE);
    send_pair(16'sh7FFF, 16'sh8000);
    send_pair(16'sh4000, -16'sh4000);
    send_pair(16'sd1, -16'sd1);
    configure(0, 16384, 0);
    send_pair(16'sh7FFF, -16'sd3);
    send_pair(16'sh8001, 16'sd1234);
    configure(2, GAIN_ONE, GAIN_ONE);
    for (int i = 0; i < 4; i++) send_pair(16'sh3000, -16'sh3000);
    configure(3, 20000, 65535);
    for (int i = 0; i < 4; i++) send_pair(16'sh8000, 16'sh7FFF);
  endtask

  // The longest tap wraps below index zero and reads entries not yet written since reset.
  task automatic test_longest_tap();
    configure(LINE_DEPTH - 1, GAIN_ONE, GAIN_ONE);
    send_pair(16'sh7FFF, 16'sh8000);
    send_pair(-16'sd2, 16'sd2);
    send_pair(16'sh1234, 16'shEDCB);
  endtask

  task automatic test_random_phases(int phases, int per_phase);
    for (int p = 0; p < phases; p++) begin
      configure(rand_length(), rand_gain(), rand_gain());
      tx_idle_en = ($urandom_range(0, 3) != 0);
      rx_idle_en = ($urandom_range(0, 3) != 0);
      for (int i = 0; i < per_phase; i++) send_pair(rand_sample(), rand_sample());
    end
    tx_idle_en = 1'b1;
    rx_idle_en = 1'b1;
  endtask

  task automatic test_backpressure();
    configure($urandom_range(1, 12), rand_gain(), rand_gain());
    tx_idle_en = 1'b0;
    @(posedge clk_i);
    rx_hold = HOLD_CYCLES;
    @(negedge clk_i);
    for (int i = 0; i < 60; i++) send_pair(rand_sample(), rand_sample());
    tx_idle_en = 1'b1;
  endtask

  initial begin
    wr_ptr  = '0;
    cfg_len = LEN_W'(LEN_RESET);
    cfg_mix = '0;
    cfg_fb  = '0;
    for (int i = 0; i < LINE_DEPTH; i++) begin
      line_mem[0][i] = '0;
      line_mem[1][i] = '0;
    end
    repeat (8) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni = 1'b1;
    @(negedge clk_i);

    test_reset_bypass();
    test_short_taps();
    test_longest_tap();
    test_random_phases(9, 115);
    test_backpressure();
    drain();

    $display("Ran %0d sample pairs through %0d delay/gain settings; %0d results compared.",
             pairs_sent, settings_count, pairs_checked);
    $display("Taps from one to the full line, gains past unity, and a %0d-cycle output stall.",
             HOLD_CYCLES);
    if (mismatches == 0 && pending_pairs.size() == 0) begin
      $display("CHECK OK");
    end else begin
      $display("CHECK FAILED");
    end
    $finish;
  end

endmodule
